/* rtl/core/ptr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptr_pkg: shared definitions for the pulse tachometer
// Request and status codes, fixed field widths, rate constants and the
// structs between the sequencer and the shared divider.
// ----------------------------------------------------------------------------
package ptr_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned RAW_W         = 15;
  localparam int unsigned RPM_W         = 40;
  localparam int unsigned FRACTION_BITS = 8;
  localparam int unsigned MUL_W         = 26;
  localparam int unsigned PROD_W        = WORD_W + MUL_W;
  localparam int unsigned DIV_W         = PROD_W + FRACTION_BITS;
  localparam int unsigned CNT_W         = $clog2(DIV_W + 1);
  localparam int unsigned RECIP_W       = 29;
  localparam int unsigned MS_SHIFT      = 38;
  localparam int unsigned MUL_OUT_W     = WORD_W + RECIP_W;

  localparam logic [WORD_W-1:0]  COUNTER_LIMIT = 32'd32767;
  localparam logic [MUL_W-1:0]   US_PER_MINUTE = 26'd60000000;
  localparam logic [WORD_W-1:0]  US_PER_MS     = 32'd1000;
  localparam logic [WORD_W-1:0]  STALL_RESET   = 32'd500;
  // ceil(2^38 / 1000), exact floor of x / 1000 for any 32-bit x
  localparam logic [RECIP_W-1:0] MS_RECIP      = 29'd274877907;

  typedef enum logic [1:0] {
    REQ_OVERFLOW = 2'd0,
    REQ_READ     = 2'd1,
    REQ_RESTART  = 2'd2
  } req_type_e;

  typedef enum logic [2:0] {
    STAT_VALID        = 3'd0,
    STAT_DISABLED     = 3'd1,
    STAT_PRIMING      = 3'd2,
    STAT_STALLED      = 3'd3,
    STAT_ZERO_ELAPSED = 3'd4
  } status_e;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/core/ptr_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptr_req_if: request channel
// Valid/ready channel carrying one tachometer request item.
// ----------------------------------------------------------------------------
interface ptr_req_if;
  logic                           valid;
  logic                           ready;
  ptr_pkg::req_type_e             req_type;
  logic [ptr_pkg::RAW_W-1:0]      raw_count;
  logic [ptr_pkg::WORD_W-1:0]     now_us;

  modport source (output valid, req_type, raw_count, now_us, input ready);
  modport sink   (input valid, req_type, raw_count, now_us, output ready);
endinterface

/* rtl/core/ptr_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptr_rsp_if: result channel
// Valid/ready channel carrying one rate read result item.
// ----------------------------------------------------------------------------
interface ptr_rsp_if;
  logic                          valid;
  logic                          ready;
  ptr_pkg::status_e              status;
  logic [ptr_pkg::RPM_W-1:0]     rpm_q8;
  logic [ptr_pkg::WORD_W-1:0]    pulse_count;
  logic [ptr_pkg::WORD_W-1:0]    total_pulses;
  logic [ptr_pkg::WORD_W-1:0]    overflow_events;
  logic [ptr_pkg::WORD_W-1:0]    ms_since_pulse;

  modport source (output valid, status, rpm_q8, pulse_count, total_pulses,
                  overflow_events, ms_since_pulse, input ready);
  modport sink   (input valid, status, rpm_q8, pulse_count, total_pulses,
                  overflow_events, ms_since_pulse, output ready);
endinterface

/* rtl/core/pulse_tachometer_rpm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_tachometer_rpm: pulse count tachometer back end
// Counter overflow and restart items are handled in the idle state and give
// no result. A rate read while enabled that yields a rate runs ST_EVAL and
// ST_BOOK, a reciprocal multiply for the milliseconds since the last pulse,
// a second multiply on the same multiplier, and a 66-step pass of the shared
// divider, one quotient bit per cycle, for the rpm quotient. A priming,
// stalled or zero-elapsed read ends at ST_MS_CHECK, and a read while disabled
// goes straight to ST_FINISH. One item is worked on at a time, and a new
// item is taken while the last result still waits in the output register; a
// finished read holds the input off until that register is free.
// ----------------------------------------------------------------------------
module pulse_tachometer_rpm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ptr_pkg::WORD_W-1:0] cfg_wdata_i,
  ptr_req_if.sink                    req_i,
  ptr_rsp_if.source                  rsp_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_BOOK,
    ST_MS_MUL,
    ST_MS_CHECK,
    ST_MUL,
    ST_RATE_START,
    ST_RATE_WAIT,
    ST_FINISH
  } state_e;

  state_e                        state_q;

  logic [ptr_pkg::WORD_W-1:0]    timeout_q;
  logic                          enabled_q;
  logic [ptr_pkg::WORD_W-1:0]    ovf_total_q;
  logic [ptr_pkg::WORD_W-1:0]    last_total_q;
  logic [ptr_pkg::WORD_W-1:0]    last_read_q;
  logic [ptr_pkg::WORD_W-1:0]    last_pulse_q;
  logic [ptr_pkg::WORD_W-1:0]    pulse_sum_q;
  logic [ptr_pkg::WORD_W-1:0]    tally_q;

  logic [ptr_pkg::WORD_W-1:0]    now_q;
  logic [ptr_pkg::RAW_W-1:0]     raw_q;
  logic [ptr_pkg::WORD_W-1:0]    total_q;
  logic [ptr_pkg::WORD_W-1:0]    pulses_q;
  logic [ptr_pkg::WORD_W-1:0]    elapsed_q;
  logic                          priming_q;
  logic [ptr_pkg::MUL_OUT_W-1:0] product_q;

  ptr_pkg::status_e              res_status_q;
  logic [ptr_pkg::RPM_W-1:0]     res_rpm_q;
  logic [ptr_pkg::WORD_W-1:0]    res_count_q;
  logic [ptr_pkg::WORD_W-1:0]    res_ms_q;

  logic                          out_valid_q;
  ptr_pkg::status_e              out_status_q;
  logic [ptr_pkg::RPM_W-1:0]     out_rpm_q;
  logic [ptr_pkg::WORD_W-1:0]    out_count_q;
  logic [ptr_pkg::WORD_W-1:0]    out_sum_q;
  logic [ptr_pkg::WORD_W-1:0]    out_tally_q;
  logic [ptr_pkg::WORD_W-1:0]    out_ms_q;

  logic [ptr_pkg::WORD_W-1:0]    diff;
  logic [ptr_pkg::WORD_W-1:0]    pulses_c;
  logic [ptr_pkg::WORD_W-1:0]    ms_quot;
  logic [ptr_pkg::WORD_W-1:0]    mul_a;
  logic [ptr_pkg::RECIP_W-1:0]   mul_b;
  logic                          req_acc;

  ptr_pkg::div_req_t             div_req;
  ptr_pkg::div_rsp_t             div_rsp;

  ptr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_req),
    .stat_o (div_rsp)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  always_comb begin
    diff     = total_q - last_total_q;
    pulses_c = diff[ptr_pkg::WORD_W-1] ? ptr_pkg::WORD_W'(raw_q) : diff;
    ms_quot  = ptr_pkg::WORD_W'(product_q[ptr_pkg::MUL_OUT_W-1:ptr_pkg::MS_SHIFT]);
  end

  // shared multiplier operands
  always_comb begin
    if (state_q == ST_MS_MUL) begin
      mul_a = now_q - last_pulse_q;
      mul_b = ptr_pkg::MS_RECIP;
    end else begin
      mul_a = pulses_q;
      mul_b = ptr_pkg::RECIP_W'(ptr_pkg::US_PER_MINUTE);
    end
  end

  always_comb begin
    div_req.start    = (state_q == ST_RATE_START);
    div_req.dividend = ptr_pkg::DIV_W'(product_q[ptr_pkg::PROD_W-1:0])
                       << ptr_pkg::FRACTION_BITS;
    div_req.divisor  = elapsed_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      timeout_q    <= ptr_pkg::STALL_RESET;
      enabled_q    <= 1'b0;
      ovf_total_q  <= '0;
      last_total_q <= '0;
      last_read_q  <= '0;
      last_pulse_q <= '0;
      pulse_sum_q  <= '0;
      tally_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (rsp_o.valid && rsp_o.ready && state_q != ST_FINISH) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (req_acc) begin
            now_q   <= req_i.now_us;
            raw_q   <= req_i.raw_count;
            total_q <= ovf_total_q + ptr_pkg::WORD_W'(req_i.raw_count);
            case (req_i.req_type)
              ptr_pkg::REQ_OVERFLOW: begin
                if (enabled_q) begin
                  ovf_total_q <= ovf_total_q + ptr_pkg::COUNTER_LIMIT;
                  tally_q     <= tally_q + 1'b1;
                end
              end
              ptr_pkg::REQ_RESTART: begin
                ovf_total_q  <= '0;
                last_total_q <= '0;
                last_read_q  <= req_i.now_us;
                last_pulse_q <= '0;
                pulse_sum_q  <= '0;
                tally_q      <= '0;
                enabled_q    <= 1'b1;
              end
              ptr_pkg::REQ_READ: begin
                if (enabled_q) begin
                  state_q <= ST_EVAL;
                end else begin
                  res_status_q <= ptr_pkg::STAT_DISABLED;
                  res_rpm_q    <= '0;
                  res_count_q  <= '0;
                  res_ms_q     <= '1;
                  state_q      <= ST_FINISH;
                end
              end
              default: ;
            endcase
          end
        end

        ST_EVAL: begin
          res_count_q  <= total_q;
          priming_q    <= (last_read_q == '0);
          pulses_q     <= pulses_c;
          elapsed_q    <= now_q - last_read_q;
          last_total_q <= total_q;
          last_read_q  <= now_q;
          state_q      <= ST_BOOK;
        end

        ST_BOOK: begin
          // pulse bookkeeping only on a measuring read
          if (!priming_q && pulses_q != '0) begin
            last_pulse_q <= now_q;
            pulse_sum_q  <= pulse_sum_q + pulses_q;
          end
          state_q <= ST_MS_MUL;
        end

        ST_MS_MUL: begin
          product_q <= mul_a * mul_b;
          state_q   <= ST_MS_CHECK;
        end

        ST_MS_CHECK: begin
          res_ms_q  <= (last_pulse_q != '0) ? ms_quot : '1;
          res_rpm_q <= '0;
          if (priming_q) begin
            res_status_q <= ptr_pkg::STAT_PRIMING;
            state_q      <= ST_FINISH;
          end else if (last_pulse_q != '0 && ms_quot > timeout_q) begin
            res_status_q <= ptr_pkg::STAT_STALLED;
            state_q      <= ST_FINISH;
          end else if (elapsed_q == '0) begin
            res_status_q <= ptr_pkg::STAT_ZERO_ELAPSED;
            state_q      <= ST_FINISH;
          end else begin
            state_q <= ST_MUL;
          end
        end

        ST_MUL: begin
          product_q <= mul_a * mul_b;
          state_q   <= ST_RATE_START;
        end

        ST_RATE_START: begin
          state_q <= ST_RATE_WAIT;
        end

        ST_RATE_WAIT: begin
          if (div_rsp.done) begin
            res_status_q <= ptr_pkg::STAT_VALID;
            // saturate when the quotient overflows the result width
            if (div_rsp.quotient[ptr_pkg::DIV_W-1:ptr_pkg::RPM_W] != '0) begin
              res_rpm_q <= '1;
            end else begin
              res_rpm_q <= div_rsp.quotient[ptr_pkg::RPM_W-1:0];
            end
            state_q <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_rpm_q    <= res_rpm_q;
            out_count_q  <= res_count_q;
            out_sum_q    <= pulse_sum_q;
            out_tally_q  <= tally_q;
            out_ms_q     <= res_ms_q;
            state_q      <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.rpm_q8          = out_rpm_q;
  assign rsp_o.pulse_count     = out_count_q;
  assign rsp_o.total_pulses    = out_sum_q;
  assign rsp_o.overflow_events = out_tally_q;
  assign rsp_o.ms_since_pulse  = out_ms_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_RATE_WAIT)
    else $error("divider result outside the wait state");

  a_rpm_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != ptr_pkg::STAT_VALID |-> rsp_o.rpm_q8 == '0)
    else $error("nonzero rpm on a non-valid result");

  a_disabled_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status == ptr_pkg::STAT_DISABLED
      |-> rsp_o.pulse_count == '0 && rsp_o.ms_since_pulse == '1)
    else $error("disabled result carries counts");

endmodule

/* rtl/core/ptr_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptr_div: shared restoring divider
// One quotient bit per cycle over the full dividend; the quotient builds up
// in the dividend register as it shifts out.
// ----------------------------------------------------------------------------
module ptr_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptr_pkg::div_req_t ctrl_i,
  output ptr_pkg::div_rsp_t stat_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [ptr_pkg::CNT_W-1:0]     cnt_q;
  logic [ptr_pkg::DIV_W-1:0]     dvd_q;
  logic [ptr_pkg::WORD_W-1:0]    rem_q;
  logic [ptr_pkg::WORD_W-1:0]    dvs_q;
  logic [ptr_pkg::WORD_W:0]      shifted;
  logic [ptr_pkg::WORD_W:0]      trial;
  logic                          qbit;

  always_comb begin
    shifted = {rem_q, dvd_q[ptr_pkg::DIV_W-1]};
    trial   = shifted - {1'b0, dvs_q};
    qbit    = ~trial[ptr_pkg::WORD_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= ptr_pkg::CNT_W'(ptr_pkg::DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == ptr_pkg::CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      dvd_q <= ctrl_i.dividend;
      dvs_q <= ctrl_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[ptr_pkg::DIV_W-2:0], qbit};
      rem_q <= qbit ? trial[ptr_pkg::WORD_W-1:0] : shifted[ptr_pkg::WORD_W-1:0];
    end
  end

  assign stat_o.done     = done_q;
  assign stat_o.quotient = dvd_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a finished run");

  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("divider busy with zero step count");

endmodule

/* tb/pulse_tachometer_rpm_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_tachometer_rpm_tb: self-checking bench for the tachometer back end
// Sends overflow, restart and rate read items on the request channel. A
// scoreboard tracks the counters, predicts every rate read result and
// compares each field of the result. The run uses several stall timeouts
// and idle patterns on both channels.
// ----------------------------------------------------------------------------
module pulse_tachometer_rpm_tb;
  import ptr_pkg::*;

  localparam int unsigned      HALF_PERIOD     = 4;
  localparam int unsigned      RESET_CYCLES    = 6;
  localparam int unsigned      SETTLE_CYCLES   = 160;
  localparam int unsigned      ITEMS_PER_PHASE = 210;
  localparam logic [1:0]       REQ_UNUSED      = 2'd3;
  localparam logic [RPM_W-1:0] RPM_SAT         = '1;

  typedef struct packed {
    status_e           status;
    logic [RPM_W-1:0]  rpm_q8;
    logic [WORD_W-1:0] pulse_count;
    logic [WORD_W-1:0] total_pulses;
    logic [WORD_W-1:0] overflow_events;
    logic [WORD_W-1:0] ms_since_pulse;
  } rate_result_t;

  class rpm_scoreboard;
    logic [WORD_W-1:0] stall_ms;
    bit                enabled;
    logic [WORD_W-1:0] ovf_total;
    logic [WORD_W-1:0] prev_total;
    logic [WORD_W-1:0] prev_read_us;
    logic [WORD_W-1:0] pulse_seen_us;
    logic [WORD_W-1:0] pulse_sum;
    logic [WORD_W-1:0] ovf_tally;
    rate_result_t      pending_reads[$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      stall_ms      = STALL_RESET;
      enabled       = 1'b0;
      ovf_total     = '0;
      prev_total    = '0;
      prev_read_us  = '0;
      pulse_seen_us = '0;
      pulse_sum     = '0;
      ovf_tally     = '0;
      errors        = 0;
      checked       = 0;
    endfunction

    // floor(pulses * 60e6 * 2^8 / elapsed), saturated to the rpm width
    function logic [RPM_W-1:0] rpm_fixed(logic [WORD_W-1:0] pulses,
                                         logic [WORD_W-1:0] elapsed);
      logic [63:0] num;
      logic [63:0] quo;
      logic [63:0] rem;
      num = 64'(pulses) * 64'(US_PER_MINUTE);
      quo = num / 64'(elapsed);
      rem = num % 64'(elapsed);
      if (quo > 64'(RPM_SAT >> FRACTION_BITS)) return RPM_SAT;
      return RPM_W'((quo << FRACTION_BITS) + ((rem << FRACTION_BITS) / 64'(elapsed)));
    endfunction

    function void note_item(logic [1:0] req, logic [RAW_W-1:0] raw,
                            logic [WORD_W-1:0] now);
      rate_result_t      r;
      logic [WORD_W-1:0] total;
      logic [WORD_W-1:0] diff;
      logic [WORD_W-1:0] pulses;
      logic [WORD_W-1:0] elapsed;
      case (req)
        REQ_OVERFLOW: begin
          if (enabled) begin
            ovf_total = ovf_total + COUNTER_LIMIT;
            ovf_tally = ovf_tally + 1;
          end
        end
        REQ_RESTART: begin
          ovf_total     = '0;
          prev_total    = '0;
          prev_read_us  = now;
          pulse_seen_us = '0;
          pulse_sum     = '0;
          ovf_tally     = '0;
          enabled       = 1'b1;
        end
        REQ_READ: begin
          r.status         = STAT_VALID;
          r.rpm_q8         = '0;
          r.pulse_count    = '0;
          r.ms_since_pulse = '1;
          if (!enabled) begin
            r.status = STAT_DISABLED;
          end else begin
            total         = ovf_total + WORD_W'(raw);
            r.pulse_count = total;
            if (prev_read_us == '0) begin
              prev_total   = total;
              prev_read_us = now;
              r.status     = STAT_PRIMING;
            end else begin
              diff   = total - prev_total;
              // a negative difference falls back to the raw count
              pulses = diff[WORD_W-1] ? WORD_W'(raw) : diff;
              if (pulses != '0) begin
                pulse_seen_us = now;
                pulse_sum     = pulse_sum + pulses;
              end
              elapsed      = now - prev_read_us;
              prev_total   = total;
              prev_read_us = now;
              if (pulse_seen_us != '0 && (now - pulse_seen_us) / US_PER_MS > stall_ms)
                r.status = STAT_STALLED;
              else if (elapsed == '0)
                r.status = STAT_ZERO_ELAPSED;
              else
                r.rpm_q8 = rpm_fixed(pulses, elapsed);
            end
            if (pulse_seen_us != '0) r.ms_since_pulse = (now - pulse_seen_us) / US_PER_MS;
          end
          r.total_pulses    = pulse_sum;
          r.overflow_events = ovf_tally;
          pending_reads.push_back(r);
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task compare(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    task check_result(rate_result_t got);
      rate_result_t want;
      if (pending_reads.size() == 0) begin
        report($sformatf("rate result with nothing pending, status %0d", got.status));
        return;
      end
      want = pending_reads.pop_front();
      checked++;
      compare("status", got.status, want.status);
      compare("rpm_q8", got.rpm_q8, want.rpm_q8);
      compare("pulse_count", got.pulse_count, want.pulse_count);
      compare("total_pulses", got.total_pulses, want.total_pulses);
      compare("overflow_events", got.overflow_events, want.overflow_events);
      compare("ms_since_pulse", got.ms_since_pulse, want.ms_since_pulse);
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [WORD_W-1:0] cfg_wdata;
  int unsigned       send_gap_pct;
  int unsigned       recv_stall_pct;
  int unsigned       sent_items;
  logic [WORD_W-1:0] mid_timeout;
  rpm_scoreboard     sb;

  ptr_req_if req_if ();
  ptr_rsp_if rsp_if ();

  pulse_tachometer_rpm u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always #HALF_PERIOD clk = ~clk;

  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rate_result_t seen;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        seen.status          = rsp_if.status;
        seen.rpm_q8          = rsp_if.rpm_q8;
        seen.pulse_count     = rsp_if.pulse_count;
        seen.total_pulses    = rsp_if.total_pulses;
        seen.overflow_events = rsp_if.overflow_events;
        seen.ms_since_pulse  = rsp_if.ms_since_pulse;
        sb.check_result(seen);
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_item(logic [1:0] req, logic [RAW_W-1:0] raw, logic [WORD_W-1:0] now);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= req_type_e'(req);
    req_if.raw_count <= raw;
    req_if.now_us    <= now;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    sb.note_item(req, raw, now);
    sent_items++;
  endtask

  // hold the request channel until every pending read has come back
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_reads.size() != 0);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_stall(logic [WORD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    sb.stall_ms  = value;
  endtask

  task automatic run_directed();
    send_item(REQ_READ, '1, '1);
    send_item(REQ_OVERFLOW, '0, '0);
    send_item(REQ_UNUSED, '1, '1);
    send_item(REQ_RESTART, '0, '0);
    send_item(REQ_READ, '0, 32'd100);
    send_item(REQ_READ, '0, 32'd1100);
    send_item(REQ_READ, 15'd10, 32'd2100);
    send_item(REQ_READ, 15'd10, 32'd2100);
    send_item(REQ_OVERFLOW, '0, '0);
    send_item(REQ_OVERFLOW, '0, '0);
    send_item(REQ_READ, '1, 32'd3100);
    send_item(REQ_READ, 15'd5, 32'd3200);
    send_item(REQ_READ, 15'd5, 32'd603200);
    send_item(REQ_RESTART, '0, 32'hFFFF_FFF0);
    send_item(REQ_READ, '1, 32'hFFFF_FFF1);
    send_item(REQ_READ, '1, 32'h0000_0100);
    send_item(REQ_OVERFLOW, '1, '1);
    send_item(REQ_OVERFLOW, '0, '0);
    send_item(REQ_OVERFLOW, '0, '0);
    send_item(REQ_READ, '0, 32'h0001_0000);
    send_item(REQ_RESTART, '1, 32'h8000_0000);
    send_item(REQ_READ, 15'd1, 32'h8000_0000);
    send_item(REQ_READ, 15'd1, 32'hFFFF_FFFF);
  endtask

  task automatic run_random(int unsigned n);
    int unsigned       done_items;
    bit                drained;
    logic [1:0]        req;
    logic [WORD_W-1:0] t;
    int unsigned       hw;
    int unsigned       p;
    int unsigned       dt;
    done_items = 0;
    drained    = 1'b0;
    while (done_items < n) begin
      if ((!drained && done_items >= n / 2) || $urandom_range(0, 59) == 0) begin
        drain();
        drained = 1'b1;
      end
      if ($urandom_range(0, 99) < 15) begin
        req = 2'($urandom_range(0, 3));
        send_item(req, 15'($urandom), $urandom);
        if (req != REQ_UNUSED) done_items++;
      end else begin
        t  = ($urandom_range(0, 9) == 0) ? '0 : $urandom;
        hw = $urandom_range(0, COUNTER_LIMIT);
        send_item(REQ_RESTART, 15'($urandom), t);
        done_items++;
        repeat ($urandom_range(1, 12)) begin
          case ($urandom_range(0, 9))
            0, 1:    p = 0;
            2, 3, 4: p = $urandom_range(1, 100);
            5, 6, 7, 8: p = $urandom_range(101, 5000);
            default: p = $urandom_range(5001, 70000);
          endcase
          hw += p;
          while (hw > COUNTER_LIMIT) begin
            // now and then an overflow item is lost
            if ($urandom_range(0, 19) != 0) begin
              send_item(REQ_OVERFLOW, 15'($urandom), $urandom);
              done_items++;
            end
            hw -= COUNTER_LIMIT;
          end
          case ($urandom_range(0, 19))
            0:       dt = 0;
            1, 2, 3, 4, 5, 6, 7, 8, 9: dt = $urandom_range(1, 5000);
            10, 11, 12, 13, 14, 15: dt = $urandom_range(5001, 200000);
            16, 17, 18: dt = $urandom_range(200001, 3000000);
            default: dt = $urandom;
          endcase
          t = t + dt;
          send_item(REQ_READ, 15'(hw), t);
          done_items++;
        end
      end
    end
  endtask

  initial begin
    sb              = new();
    send_gap_pct    = 0;
    recv_stall_pct  = 0;
    sent_items      = 0;
    mid_timeout     = $urandom_range(1, 3000);
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    req_if.valid     <= 1'b0;
    req_if.req_type  <= REQ_OVERFLOW;
    req_if.raw_count <= '0;
    req_if.now_us    <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_stall(STALL_RESET);
    run_directed();

    settle();
    write_stall('0);
    send_gap_pct   = 12;
    recv_stall_pct = 48;
    run_random(ITEMS_PER_PHASE);

    settle();
    write_stall('1);
    send_gap_pct   = 48;
    recv_stall_pct = 12;
    run_random(ITEMS_PER_PHASE);

    settle();
    write_stall(mid_timeout);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_random(ITEMS_PER_PHASE);

    settle();
    $display("summary: %0d request items sent, %0d rate results checked", sent_items,
             sb.checked);
    $display("summary: stall timeouts 500, 0, all ones and %0d ms", mid_timeout);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/ptr_pkg.sv
rtl/core/ptr_req_if.sv
rtl/core/ptr_rsp_if.sv
rtl/core/ptr_div.sv
rtl/core/pulse_tachometer_rpm.sv
tb/pulse_tachometer_rpm_tb.sv
